[hw/rtl/sha224_pkg.sv]
// SHA-224 shared package: round constants, initial hash, control struct
// and the sigma functions used by the schedule and round datapaths.
// No dependencies.
`default_nettype none

package sha224_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned NUM_VARS = 8;
    localparam int unsigned WIN_LEN  = 16;
    localparam int unsigned ROUNDS   = 64;

    localparam logic [3:0] LAST_WORD_POS = 4'd15;
    localparam logic [5:0] LAST_ROUND    = 6'd63;
    localparam logic [2:0] DIGEST_LAST   = 3'd6;

    // Sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_ROUND  = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;
    localparam logic [1:0] ST_OUT    = 2'd3;

    typedef logic [WORD_W-1:0] t_word;

    // Controls from the sequencer to the hash datapath
    typedef struct packed {
        logic load_init;   // load the SHA-224 initial hash
        logic load_vars;   // copy hash words into the working variables
        logic round_en;    // run one compression round
        logic update;      // add the working variables into the hash
    } t_round_ctrl;

    localparam t_word INIT_HASH [NUM_VARS] = '{
        32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
        32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
    };

    localparam t_word ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word big_sigma0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/sha224_block_hasher.sv]
// SHA-224 block hasher top level: handshakes, word and round sequencer,
// digest output. Uses sha224_pkg, sha224_sched and sha224_round.
//
// Input stream: one 32-bit big-endian word of a padded message per
// transaction; tuser is the first-of-message flag (loads the SHA-224
// initial hash and restarts the block), tlast marks the final block.
// Message words are taken one per cycle while the block is idle. After the
// sixteenth word of a block, tready drops for the 64 rounds on the
// one round unit (one round per cycle) and the add into the hash.
// If the block was final, seven digest words follow on the output stream,
// most significant first, tuser holding the word index and tlast set on
// the seventh. The first digest word is valid on the cycle after the hash
// update. The output holds while the receiver stalls and no new word is
// taken until the seventh digest transaction completes.
// Reset loads the SHA-224 initial hash and clears the word count and the
// final-block flag.
`default_nettype none

module sha224_block_hasher (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  wire [31:0] i_s_axis_tdata,   // [31:0] message_word
    input  wire [0:0]  i_s_axis_tuser,   // [0] first_of_message
    input  wire        i_s_axis_tlast,   // last_of_message
    output logic       o_m_axis_tvalid,
    input  wire        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // [31:0] digest_word
    output logic [2:0] o_m_axis_tuser,   // [2:0] digest_index
    output logic       o_m_axis_tlast    // last_digest_word
);

    logic [1:0] r_state, n_state;
    logic [3:0] r_count, n_count;
    logic       r_final, n_final;
    logic [5:0] r_round, n_round;
    logic [2:0] r_idx,   n_idx;

    logic       s_accept;
    logic       m_accept;
    sha224_pkg::t_round_ctrl ctrl;
    sha224_pkg::t_word       sched_w;
    sha224_pkg::t_word       rd_word;

    assign o_s_axis_tready = (r_state == sha224_pkg::ST_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = (r_state == sha224_pkg::ST_OUT);
    assign m_accept        = o_m_axis_tvalid && i_m_axis_tready;

    // Sequencer: collect words, run rounds, update, emit digest
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_final = r_final;
        n_round = r_round;
        n_idx   = r_idx;
        ctrl    = '0;
        case (r_state)
            sha224_pkg::ST_IDLE: begin
                if (s_accept) begin
                    ctrl.load_init = i_s_axis_tuser[0];
                    if (i_s_axis_tuser[0]) begin
                        n_count = 4'd1;
                        n_final = i_s_axis_tlast;
                    end else if (r_count == sha224_pkg::LAST_WORD_POS) begin
                        ctrl.load_vars = 1'b1;
                        n_count = 4'd0;
                        n_final = r_final || i_s_axis_tlast;
                        n_round = 6'd0;
                        n_state = sha224_pkg::ST_ROUND;
                    end else begin
                        n_count = r_count + 4'd1;
                        n_final = r_final || i_s_axis_tlast;
                    end
                end
            end
            sha224_pkg::ST_ROUND: begin
                ctrl.round_en = 1'b1;
                n_round = r_round + 6'd1;
                if (r_round == sha224_pkg::LAST_ROUND) begin
                    n_state = sha224_pkg::ST_UPDATE;
                end
            end
            sha224_pkg::ST_UPDATE: begin
                ctrl.update = 1'b1;
                n_idx = 3'd0;
                if (r_final) begin
                    n_final = 1'b0;
                    n_state = sha224_pkg::ST_OUT;
                end else begin
                    n_state = sha224_pkg::ST_IDLE;
                end
            end
            sha224_pkg::ST_OUT: begin
                if (m_accept) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == sha224_pkg::DIGEST_LAST) begin
                        n_state = sha224_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = sha224_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha224_pkg::ST_IDLE;
            r_count <= 4'd0;
            r_final <= 1'b0;
            r_round <= 6'd0;
            r_idx   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_final <= n_final;
            r_round <= n_round;
            r_idx   <= n_idx;
        end
    end

    sha224_sched u_sched (
        .i_clk     (i_clk),
        .i_load    (s_accept),
        .i_word    (i_s_axis_tdata),
        .i_advance (ctrl.round_en),
        .o_w       (sched_w)
    );

    sha224_round u_round (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ctrl),
        .i_k       (sha224_pkg::ROUND_K[r_round]),
        .i_w       (sched_w),
        .i_rd_idx  (r_idx),
        .o_rd_word (rd_word)
    );

    // Drive the digest word straight from the hash registers
    assign o_m_axis_tdata = rd_word;
    assign o_m_axis_tuser = r_idx;
    assign o_m_axis_tlast = (r_idx == sha224_pkg::DIGEST_LAST);

endmodule

`default_nettype wire

[hw/rtl/sha224_sched.sv]
// SHA-224 message schedule: a 16-word shift window that takes message words
// while loading and expands one schedule word per round. Uses sha224_pkg.
`default_nettype none

module sha224_sched (
    input  wire                 i_clk,
    input  wire                 i_load,     // shift in a message word
    input  wire sha224_pkg::t_word i_word,
    input  wire                 i_advance,  // consume one word, append W[t+16]
    output sha224_pkg::t_word   o_w         // schedule word for this round
);

    sha224_pkg::t_word r_win [sha224_pkg::WIN_LEN];
    sha224_pkg::t_word n_expand;
    sha224_pkg::t_word n_tail;

    // Next schedule word from the fixed window taps
    always_comb begin
        n_expand = sha224_pkg::small_sigma1(r_win[14]) + r_win[9]
                 + sha224_pkg::small_sigma0(r_win[1]) + r_win[0];
        n_tail   = i_load ? i_word : n_expand;
    end

    // Shift the window toward entry 0
    always_ff @(posedge i_clk) begin
        if (i_load || i_advance) begin
            for (int i = 0; i < sha224_pkg::WIN_LEN - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[sha224_pkg::WIN_LEN-1] <= n_tail;
        end
    end

    assign o_w = r_win[0];

endmodule

`default_nettype wire

[hw/rtl/sha224_round.sv]
// SHA-224 hash state and compression round: eight hash words, eight working
// variables and one shared round unit. Uses sha224_pkg.
`default_nettype none

module sha224_round (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire sha224_pkg::t_round_ctrl i_ctrl,
    input  wire sha224_pkg::t_word  i_k,
    input  wire sha224_pkg::t_word  i_w,
    input  wire [2:0]               i_rd_idx,
    output sha224_pkg::t_word       o_rd_word
);

    sha224_pkg::t_word r_hash [sha224_pkg::NUM_VARS];
    sha224_pkg::t_word r_v    [sha224_pkg::NUM_VARS];
    sha224_pkg::t_word n_t1;
    sha224_pkg::t_word n_t2;

    // One round: T1 and T2 from the current working variables
    always_comb begin
        n_t1 = r_v[7] + sha224_pkg::big_sigma1(r_v[4])
             + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + i_k + i_w;
        n_t2 = sha224_pkg::big_sigma0(r_v[0])
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // Hash state: initial value, or accumulate after a block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.load_init) begin
            for (int i = 0; i < sha224_pkg::NUM_VARS; i++) begin
                r_hash[i] <= sha224_pkg::INIT_HASH[i];
            end
        end else if (i_ctrl.update) begin
            for (int i = 0; i < sha224_pkg::NUM_VARS; i++) begin
                r_hash[i] <= r_hash[i] + r_v[i];
            end
        end
    end

    // Working variables: seed from hash, then rotate through the rounds
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_vars) begin
            for (int i = 0; i < sha224_pkg::NUM_VARS; i++) begin
                r_v[i] <= r_hash[i];
            end
        end else if (i_ctrl.round_en) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + n_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= n_t1 + n_t2;
        end
    end

    assign o_rd_word = r_hash[i_rd_idx];

endmodule

`default_nettype wire
